>>> hdl/mmqe_pkg.sv
`timescale 1ns / 1ps
// mmqe_pkg: shared types, codes and defaults for the mailbox message queue engine.
// No dependencies; used by mailbox_message_queue_engine.
package mmqe_pkg;

  // default sizes
  localparam int POOL_BLOCKS_DEF = 64;
  localparam int MAILBOXES_DEF   = 16;
  localparam int WORD_WIDTH_DEF  = 32;

  // fixed field widths
  localparam int CMD_W    = 2;
  localparam int MBX_W    = 4;
  localparam int STRAT_W  = 2;
  localparam int LIMIT_W  = 7;
  localparam int STATUS_W = 3;
  localparam int QUEUED_W = 7;
  localparam int MISSED_W = 16;

  localparam logic [MISSED_W-1:0] MISSED_MAX = '1;
  localparam logic [LIMIT_W-1:0]  DEF_LIMIT  = 7'd8;

  // commands
  localparam logic [CMD_W-1:0] CMD_POST = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RECV = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SET  = 2'd3;

  // overflow strategies
  localparam logic [STRAT_W-1:0] STRAT_UNLIMITED = 2'd0;
  localparam logic [STRAT_W-1:0] STRAT_NEWEST    = 2'd1;
  localparam logic [STRAT_W-1:0] STRAT_OLDEST    = 2'd2;
  localparam logic [STRAT_W-1:0] STRAT_BAD       = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL       = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_POOL_EMPTY = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NO_MSG     = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_BAD_ARG    = 3'd4;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_ALLOC,
    S_POST,
    S_APP,
    S_DRD,
    S_DRW,
    S_WKR,
    S_WKD,
    S_SPL,
    S_SPD,
    S_SP2,
    S_FREEALL,
    S_RDH,
    S_DONE
  } mq_state_t;

endpackage

>>> hdl/mailbox_message_queue_engine.sv
`timescale 1ns / 1ps
// Mailbox message queue engine: mailbox table, block link and payload memories, sequencer.
// Depends on mmqe_pkg.
//
// Usage:
//   Input channel (in_*): one command per transfer: post, receive, peek or set.
//   Output channel (out_*): exactly one result per command, in command order.
//   The block works on one command at a time; in_stall is high while it is busy.
//   Keep-newest overflow drops head messages one by one; keep-oldest overflow either
//   drops the new message or walks the list to the block that becomes the tail and
//   trims the run behind it (limit zero: all messages). Each list step goes through
//   the link memory, whose reads are registered.
//   The result sits in an output register; a command is taken in the cycle after it loads.
//   While out_stall is high the result holds and the next result waits in the finish
//   state. Reset empties all mailboxes, restores keep-newest with limit 8 and frees the
//   whole pool at once (no clearing pass).
module mailbox_message_queue_engine #(
  parameter int POOL_BLOCKS = mmqe_pkg::POOL_BLOCKS_DEF,
  parameter int MAILBOXES   = mmqe_pkg::MAILBOXES_DEF,
  parameter int WORD_WIDTH  = mmqe_pkg::WORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mmqe_pkg::CMD_W-1:0]      in_cmd,
  input  logic [mmqe_pkg::MBX_W-1:0]      in_mailbox,
  input  logic [WORD_WIDTH-1:0]           in_word_one,
  input  logic [WORD_WIDTH-1:0]           in_word_two,
  input  logic [WORD_WIDTH-1:0]           in_word_three,
  input  logic [mmqe_pkg::STRAT_W-1:0]    in_new_strategy,
  input  logic [mmqe_pkg::LIMIT_W-1:0]    in_new_size,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mmqe_pkg::STATUS_W-1:0]   out_status,
  output logic [WORD_WIDTH-1:0]           out_out_one,
  output logic [WORD_WIDTH-1:0]           out_out_two,
  output logic [WORD_WIDTH-1:0]           out_out_three,
  output logic [mmqe_pkg::QUEUED_W-1:0]   out_queued,
  output logic [mmqe_pkg::MISSED_W-1:0]   out_missed
);

  localparam int HW  = $clog2(POOL_BLOCKS + 1);
  localparam int AW  = $clog2(POOL_BLOCKS);
  localparam int CW  = (HW > mmqe_pkg::LIMIT_W) ? HW : mmqe_pkg::LIMIT_W;
  localparam int MBW = (MAILBOXES > 1) ? $clog2(MAILBOXES) : 1;
  localparam int PW  = 3 * WORD_WIDTH;
  localparam int SW  = mmqe_pkg::MISSED_W + 1;

  typedef struct packed {
    logic [HW-1:0]                    head;
    logic [HW-1:0]                    tail;
    logic [CW-1:0]                    count;
    logic [mmqe_pkg::MISSED_W-1:0]    missed;
    logic [mmqe_pkg::STRAT_W-1:0]     strat;
    logic [mmqe_pkg::LIMIT_W-1:0]     limit;
  } mb_t;

  localparam mb_t MB_DEF = '{head: '0, tail: '0, count: '0, missed: '0,
                             strat: mmqe_pkg::STRAT_NEWEST, limit: mmqe_pkg::DEF_LIMIT};

  // memories
  logic [HW-1:0] link_mem [POOL_BLOCKS];
  logic [PW-1:0] pay_mem  [POOL_BLOCKS];
  mb_t           mb_mem   [MAILBOXES];
  logic [MAILBOXES-1:0] mbv_r;

  logic [HW-1:0] link_q;
  logic [PW-1:0] pay_q;
  mb_t           mb_q;
  logic          mbv_q;

  // memory controls
  logic [HW-1:0] blk_rd_h;
  logic          link_we;
  logic [HW-1:0] link_wh, link_wd;
  logic          pay_we;
  logic [HW-1:0] pay_wh;
  logic          mb_we;

  // sequencer and working registers
  mmqe_pkg::mq_state_t state_r, state_nxt;
  logic [mmqe_pkg::CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [mmqe_pkg::MBX_W-1:0]    mbx_r, mbx_nxt;
  logic                          bad_r, bad_nxt;
  logic [PW-1:0]                 words_r, words_nxt;
  logic [mmqe_pkg::STRAT_W-1:0]  sin_r, sin_nxt;
  logic [mmqe_pkg::LIMIT_W-1:0]  size_r, size_nxt;
  mb_t                           mb_r, mb_nxt;
  logic [HW-1:0]                 h_r, h_nxt, t_r, t_nxt, p_r, p_nxt;
  logic [mmqe_pkg::LIMIT_W-1:0]  k_r, k_nxt;
  logic [HW-1:0]                 rel_r, rel_nxt, fresh_r, fresh_nxt, free_r, free_nxt;
  logic [mmqe_pkg::STATUS_W-1:0] stat_r, stat_nxt;
  logic [PW-1:0]                 odat_r, odat_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [mmqe_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [PW-1:0]                 out_data_r, out_data_nxt;
  logic [mmqe_pkg::QUEUED_W-1:0] out_queued_r, out_queued_nxt;
  logic [mmqe_pkg::MISSED_W-1:0] out_missed_r, out_missed_nxt;

  // shared conditions
  mb_t           mb_eff;
  logic          in_xfer, out_free;
  logic [CW-1:0] lim_ext;
  logic          over_old, drop_more, drw_more;
  logic [CW:0]   gap;
  logic [SW-1:0] miss_gap_sum, miss_one_sum;
  logic [mmqe_pkg::MISSED_W-1:0] miss_gap, miss_one;
  logic [MBW-1:0] idx_r;

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign mb_eff   = mbv_q ? mb_q : MB_DEF;
  assign idx_r    = MBW'(mbx_r);
  assign lim_ext  = CW'(mb_r.limit);
  assign over_old = (mb_r.strat == mmqe_pkg::STRAT_OLDEST) && (mb_r.count >= lim_ext);
  assign drop_more = (mb_r.strat == mmqe_pkg::STRAT_NEWEST) && (mb_r.count > lim_ext);
  assign drw_more  = ((mb_r.count - CW'(1)) > lim_ext) && (link_q != '0);

  // saturating drop counters
  assign gap          = {1'b0, mb_r.count} + (CW+1)'(1) - {1'b0, lim_ext};
  assign miss_gap_sum = {1'b0, mb_r.missed} + SW'(gap);
  assign miss_one_sum = {1'b0, mb_r.missed} + SW'(1);
  assign miss_gap = miss_gap_sum[SW-1] ? mmqe_pkg::MISSED_MAX
                                       : miss_gap_sum[mmqe_pkg::MISSED_W-1:0];
  assign miss_one = miss_one_sum[SW-1] ? mmqe_pkg::MISSED_MAX
                                       : miss_one_sum[mmqe_pkg::MISSED_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mmqe_pkg::S_IDLE: if (in_valid) state_nxt = mmqe_pkg::S_LOOK;
      mmqe_pkg::S_LOOK: begin
        if (bad_r || cmd_r == mmqe_pkg::CMD_SET) begin
          state_nxt = mmqe_pkg::S_DONE;
        end else if (cmd_r == mmqe_pkg::CMD_POST) begin
          if (free_r == '0) state_nxt = mmqe_pkg::S_DONE;
          else if (rel_r != '0) state_nxt = mmqe_pkg::S_ALLOC;
          else state_nxt = mmqe_pkg::S_POST;
        end else begin
          state_nxt = (mb_eff.count == '0) ? mmqe_pkg::S_DONE : mmqe_pkg::S_RDH;
        end
      end
      mmqe_pkg::S_ALLOC: state_nxt = mmqe_pkg::S_POST;
      mmqe_pkg::S_POST: begin
        if (!over_old) state_nxt = mmqe_pkg::S_APP;
        else if (mb_r.count == lim_ext) state_nxt = mmqe_pkg::S_DONE;
        else if (mb_r.limit == '0) state_nxt = mmqe_pkg::S_FREEALL;
        else if (mb_r.limit == mmqe_pkg::LIMIT_W'(1)) state_nxt = mmqe_pkg::S_SPL;
        else state_nxt = mmqe_pkg::S_WKR;
      end
      mmqe_pkg::S_APP: state_nxt = drop_more ? mmqe_pkg::S_DRD : mmqe_pkg::S_DONE;
      mmqe_pkg::S_DRD: state_nxt = mmqe_pkg::S_DRW;
      mmqe_pkg::S_DRW: state_nxt = drw_more ? mmqe_pkg::S_DRD : mmqe_pkg::S_DONE;
      mmqe_pkg::S_WKR: state_nxt = mmqe_pkg::S_WKD;
      mmqe_pkg::S_WKD: begin
        state_nxt = (k_r == mmqe_pkg::LIMIT_W'(1)) ? mmqe_pkg::S_SPL : mmqe_pkg::S_WKR;
      end
      mmqe_pkg::S_SPL:     state_nxt = mmqe_pkg::S_SPD;
      mmqe_pkg::S_SPD:     state_nxt = mmqe_pkg::S_SP2;
      mmqe_pkg::S_SP2:     state_nxt = mmqe_pkg::S_DONE;
      mmqe_pkg::S_FREEALL: state_nxt = mmqe_pkg::S_DONE;
      mmqe_pkg::S_RDH:     state_nxt = mmqe_pkg::S_DONE;
      mmqe_pkg::S_DONE:    if (out_free) state_nxt = mmqe_pkg::S_IDLE;
      default:             state_nxt = mmqe_pkg::S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cmd_nxt   = cmd_r;
    mbx_nxt   = mbx_r;
    bad_nxt   = bad_r;
    words_nxt = words_r;
    sin_nxt   = sin_r;
    size_nxt  = size_r;
    mb_nxt    = mb_r;
    h_nxt     = h_r;
    t_nxt     = t_r;
    p_nxt     = p_r;
    k_nxt     = k_r;
    rel_nxt   = rel_r;
    fresh_nxt = fresh_r;
    free_nxt  = free_r;
    stat_nxt  = stat_r;
    odat_nxt  = odat_r;
    blk_rd_h  = mb_r.head;
    link_we   = 1'b0;
    link_wh   = h_r;
    link_wd   = '0;
    pay_we    = 1'b0;
    pay_wh    = h_r;
    mb_we     = 1'b0;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_queued_nxt = out_queued_r;
    out_missed_nxt = out_missed_r;
    in_stall  = (state_r != mmqe_pkg::S_IDLE);

    case (state_r)
      mmqe_pkg::S_IDLE: begin
        cmd_nxt   = in_cmd;
        mbx_nxt   = in_mailbox;
        bad_nxt   = (int'(in_mailbox) >= MAILBOXES);
        words_nxt = {in_word_three, in_word_two, in_word_one};
        sin_nxt   = in_new_strategy;
        size_nxt  = in_new_size;
        stat_nxt  = mmqe_pkg::STAT_OK;
        odat_nxt  = '0;
      end
      // mailbox entry arrives: decode the command
      mmqe_pkg::S_LOOK: begin
        mb_nxt   = mb_eff;
        blk_rd_h = mb_eff.head;
        if (bad_r) begin
          mb_nxt   = '0;
          stat_nxt = mmqe_pkg::STAT_BAD_ARG;
        end else if (cmd_r == mmqe_pkg::CMD_SET) begin
          if (sin_r == mmqe_pkg::STRAT_BAD) begin
            stat_nxt = mmqe_pkg::STAT_BAD_ARG;
          end else begin
            mb_nxt.strat = sin_r;
            mb_nxt.limit = size_r;
          end
        end else if (cmd_r == mmqe_pkg::CMD_POST) begin
          if (free_r == '0) begin
            stat_nxt = mmqe_pkg::STAT_POOL_EMPTY;
          end else begin
            free_nxt = free_r - HW'(1);
            if (rel_r != '0) begin
              h_nxt    = rel_r;
              blk_rd_h = rel_r;
            end else begin
              h_nxt     = fresh_r + HW'(1);
              fresh_nxt = fresh_r + HW'(1);
            end
          end
        end else if (mb_eff.count == '0) begin
          stat_nxt = mmqe_pkg::STAT_NO_MSG;
        end
      end
      mmqe_pkg::S_ALLOC: rel_nxt = link_q;
      // new block: drop it at once, or write it and link it
      mmqe_pkg::S_POST: begin
        if (over_old) begin
          link_we  = 1'b1;
          link_wh  = h_r;
          link_wd  = rel_r;
          rel_nxt  = h_r;
          free_nxt = free_r + HW'(1);
          mb_nxt.missed = miss_gap;
          stat_nxt = mmqe_pkg::STAT_FULL;
          p_nxt    = mb_r.head;
          k_nxt    = mb_r.limit - mmqe_pkg::LIMIT_W'(1);
        end else begin
          link_we = 1'b1;
          link_wh = h_r;
          link_wd = '0;
          pay_we  = 1'b1;
          pay_wh  = h_r;
          t_nxt   = mb_r.tail;
          if (mb_r.tail == '0) mb_nxt.head = h_r;
          mb_nxt.tail  = h_r;
          mb_nxt.count = mb_r.count + CW'(1);
        end
      end
      mmqe_pkg::S_APP: begin
        link_we = (t_r != '0);
        link_wh = t_r;
        link_wd = h_r;
      end
      // keep newest: free one head message per pass
      mmqe_pkg::S_DRD: blk_rd_h = mb_r.head;
      mmqe_pkg::S_DRW: begin
        link_we  = 1'b1;
        link_wh  = mb_r.head;
        link_wd  = rel_r;
        rel_nxt  = mb_r.head;
        free_nxt = free_r + HW'(1);
        mb_nxt.head   = link_q;
        mb_nxt.count  = mb_r.count - CW'(1);
        mb_nxt.missed = miss_one;
        if (link_q == '0) mb_nxt.tail = '0;
        stat_nxt = mmqe_pkg::STAT_FULL;
      end
      // keep oldest: walk to the block that becomes the tail
      mmqe_pkg::S_WKR: blk_rd_h = p_r;
      mmqe_pkg::S_WKD: begin
        p_nxt = link_q;
        k_nxt = k_r - mmqe_pkg::LIMIT_W'(1);
      end
      mmqe_pkg::S_SPL: blk_rd_h = p_r;
      // splice the dropped tail run onto the free list
      mmqe_pkg::S_SPD: begin
        link_we  = 1'b1;
        link_wh  = mb_r.tail;
        link_wd  = rel_r;
        rel_nxt  = link_q;
        free_nxt = free_r + HW'(mb_r.count - lim_ext);
        mb_nxt.count = lim_ext;
        mb_nxt.tail  = p_r;
      end
      mmqe_pkg::S_SP2: begin
        link_we = 1'b1;
        link_wh = p_r;
        link_wd = '0;
      end
      mmqe_pkg::S_FREEALL: begin
        link_we  = 1'b1;
        link_wh  = mb_r.tail;
        link_wd  = rel_r;
        rel_nxt  = mb_r.head;
        free_nxt = free_r + HW'(mb_r.count);
        mb_nxt.head  = '0;
        mb_nxt.tail  = '0;
        mb_nxt.count = '0;
      end
      // head message read: deliver, and unlink on receive
      mmqe_pkg::S_RDH: begin
        odat_nxt = pay_q;
        if (cmd_r == mmqe_pkg::CMD_RECV) begin
          link_we  = 1'b1;
          link_wh  = mb_r.head;
          link_wd  = rel_r;
          rel_nxt  = mb_r.head;
          free_nxt = free_r + HW'(1);
          mb_nxt.head  = link_q;
          mb_nxt.count = mb_r.count - CW'(1);
          if (link_q == '0) mb_nxt.tail = '0;
        end
      end
      mmqe_pkg::S_DONE: begin
        if (out_free) begin
          mb_we          = !bad_r;
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat_r;
          out_data_nxt   = odat_r;
          out_queued_nxt = mb_r.count[mmqe_pkg::QUEUED_W-1:0];
          out_missed_nxt = mb_r.missed;
        end
      end
      default: ;
    endcase
  end

  // block memories: one read and one write port each
  always_ff @(posedge clk) begin
    if (link_we) link_mem[AW'(link_wh - HW'(1))] <= link_wd;
    if (pay_we) pay_mem[AW'(pay_wh - HW'(1))] <= words_r;
    link_q <= link_mem[AW'(blk_rd_h - HW'(1))];
    pay_q  <= pay_mem[AW'(blk_rd_h - HW'(1))];
  end

  // mailbox table memory
  always_ff @(posedge clk) begin
    if (mb_we) mb_mem[idx_r] <= mb_r;
    mb_q <= mb_mem[MBW'(in_mailbox)];
  end

  // mailbox entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbv_r <= '0;
      mbv_q <= 1'b0;
    end else begin
      if (mb_we) mbv_r[idx_r] <= 1'b1;
      mbv_q <= mbv_r[MBW'(in_mailbox)];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mmqe_pkg::S_IDLE;
      rel_r       <= '0;
      fresh_r     <= '0;
      free_r      <= HW'(POOL_BLOCKS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rel_r       <= rel_nxt;
      fresh_r     <= fresh_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and output payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    mbx_r        <= mbx_nxt;
    bad_r        <= bad_nxt;
    words_r      <= words_nxt;
    sin_r        <= sin_nxt;
    size_r       <= size_nxt;
    mb_r         <= mb_nxt;
    h_r          <= h_nxt;
    t_r          <= t_nxt;
    p_r          <= p_nxt;
    k_r          <= k_nxt;
    stat_r       <= stat_nxt;
    odat_r       <= odat_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_queued_r <= out_queued_nxt;
    out_missed_r <= out_missed_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_out_one   = out_data_r[WORD_WIDTH-1:0];
  assign out_out_two   = out_data_r[2*WORD_WIDTH-1:WORD_WIDTH];
  assign out_out_three = out_data_r[PW-1:2*WORD_WIDTH];
  assign out_queued    = out_queued_r;
  assign out_missed    = out_missed_r;

`ifndef SYNTHESIS
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= HW'(POOL_BLOCKS))
    else $error("free block count above pool size");

  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= HW'(POOL_BLOCKS))
    else $error("fresh block counter above pool size");

  a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == mmqe_pkg::S_LOOK)
    else $error("accepted command not decoded");

  a_drop_head: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mmqe_pkg::S_DRW |-> mb_r.head != '0)
    else $error("head drop on an empty queue");

  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mmqe_pkg::S_DONE && out_free) |=> out_valid_r && state_r == mmqe_pkg::S_IDLE)
    else $error("result not loaded at finish");
`endif

endmodule
